// ===== rtl/lpp_pkg.sv =====
`timescale 1ns / 1ps

package lpp_pkg;

  // Fixed widths of the datapath and of the item fields
  localparam int WORD_W       = 32;
  localparam int PROD_W       = 2 * WORD_W;
  localparam int NUM_FEATURES = 4;
  localparam int LR_W         = 17;
  localparam int FEAT_W       = 15;
  localparam int NICE_W       = 6;
  localparam int BAND_W       = 3;

  typedef logic signed [WORD_W-1:0] word_t;

  // Request sequencer
  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a request word
    S_MUL,    // lanes form w_i * x_i
    S_SUM,    // merge adds bias and lane products
    S_BAND,   // clamp score, hand band to output register
    S_STEP,   // lane 0 forms lr * error
    S_UPD,    // lanes form step * x_i
    S_APPLY   // weights and bias take the step
  } lpp_state_t;

endpackage

// ===== rtl/lpp_lane.sv =====
`timescale 1ns / 1ps

// One multiply lane: registered signed product, then fixed-point rescale.
module lpp_lane import lpp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  load,
  input  word_t op_a,
  input  word_t op_b,
  output word_t result
);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_shifted;

  // full 64-bit product, captured when the sequencer asks
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= op_a * op_b;
    end
  end

  // arithmetic shift back to the word's scale, wraps at 32 bits
  assign prod_shifted = prod >>> FRAC_BITS;
  assign result       = prod_shifted[WORD_W-1:0];

endmodule

// ===== rtl/lpp_merge.sv =====
`timescale 1ns / 1ps

// Merge stage: bias plus all lane products, then floor and clamp to a band.
module lpp_merge import lpp_pkg::*; #(
  parameter int NUM_BANDS = 8,
  parameter int FRAC_BITS = 16,
  localparam int PRED_W   = (NUM_BANDS > 2) ? $clog2(NUM_BANDS) : 1
) (
  input  logic              clk,
  input  logic              load,
  input  word_t             bias,
  input  word_t             lane_result [NUM_FEATURES],
  output logic [PRED_W-1:0] pred
);

  localparam logic [WORD_W-1:0] TOP_BAND = WORD_W'(NUM_BANDS - 1);

  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] acc_next;
  logic [WORD_W-1:0] whole;

  // wrapping sum of bias and lane products
  always_comb begin
    acc_next = bias;
    for (int i = 0; i < NUM_FEATURES; i++) begin
      acc_next = acc_next + lane_result[i];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc <= acc_next;
    end
  end

  // negative score clamps to band zero; large score saturates at top band
  assign whole = acc >> FRAC_BITS;

  always_comb begin
    if (acc[WORD_W-1]) begin
      pred = '0;
    end else if (whole >= TOP_BAND) begin
      pred = TOP_BAND[PRED_W-1:0];
    end else begin
      pred = whole[PRED_W-1:0];
    end
  end

endmodule

// ===== rtl/linear_priority_perceptron.sv =====
`timescale 1ns / 1ps

// Linear priority perceptron. Each request word carries four task features
// and a mode; four multiply lanes weight the features in parallel and a merge
// stage adds the bias and clamps the floored Q(FRAC_BITS) score to a band.
// A scoring request steps through accept, multiply, sum and clamp before the
// next acceptance; an update request adds the lr * error multiply on lane 0,
// the step * feature multiplies on all lanes and the weight/bias write. The
// clamp step waits for a free output register. The band waits in an
// output register, so a new request is taken while an earlier band is still
// stalled. Learning rate writes go through cfg_valid/cfg_data and are always
// ready; write only while idle.
module linear_priority_perceptron import lpp_pkg::*; #(
  parameter int NUM_BANDS = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     mode,
  input  logic [FEAT_W-1:0]        burst_avg,
  input  logic [FEAT_W-1:0]        io_wait,
  input  logic [FEAT_W-1:0]        age,
  input  logic signed [NICE_W-1:0] niceness,
  input  logic [BAND_W-1:0]        target_band,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [BAND_W-1:0]        band,
  // learning rate write
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LR_W-1:0]          cfg_data
);

  localparam int PRED_W = (NUM_BANDS > 2) ? $clog2(NUM_BANDS) : 1;

  // reset values scale with the fraction width
  localparam logic [WORD_W-1:0] ONE_UNIT = WORD_W'(1) << FRAC_BITS;
  localparam word_t W_RESET [NUM_FEATURES] = '{
    word_t'(ONE_UNIT / 64),
    word_t'(WORD_W'(0) - ONE_UNIT / 96),
    word_t'(WORD_W'(0) - ONE_UNIT / 128),
    word_t'(ONE_UNIT / 8)
  };
  localparam word_t BIAS_RESET = word_t'(ONE_UNIT * 2);
  localparam logic [LR_W-1:0] LR_RESET = LR_W'(ONE_UNIT / 256);

  lpp_state_t state;
  lpp_state_t state_next;

  word_t             weight [NUM_FEATURES];
  word_t             bias;
  logic [LR_W-1:0]   lrate;
  word_t             feat [NUM_FEATURES];
  logic              mode_q;
  logic [BAND_W-1:0] obs_q;
  logic [PRED_W-1:0] pred_q;
  word_t             step_q;

  logic              lane_load;
  logic              merge_load;
  logic              out_load;
  logic              out_free;
  logic              in_take;
  word_t             lane_a [NUM_FEATURES];
  word_t             lane_b [NUM_FEATURES];
  word_t             lane_result [NUM_FEATURES];
  logic [PRED_W-1:0] pred;
  logic [WORD_W-1:0] pred_w;
  logic [WORD_W-1:0] err;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_take   = in_valid && !in_stall;

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_MUL;
      S_MUL:   state_next = S_SUM;
      S_SUM:   state_next = S_BAND;
      S_BAND: begin
        if (out_free) state_next = mode_q ? S_STEP : S_IDLE;
      end
      S_STEP:  state_next = S_UPD;
      S_UPD:   state_next = S_APPLY;
      S_APPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall   = 1'b1;
    lane_load  = 1'b0;
    merge_load = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE:  in_stall = 1'b0;
      S_MUL:   lane_load = 1'b1;
      S_SUM:   merge_load = 1'b1;
      S_BAND:  out_load = out_free;
      S_STEP:  lane_load = 1'b1;
      S_UPD:   lane_load = 1'b1;
      S_APPLY: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // latch request word, features pre-shifted to the fixed-point scale
  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_q  <= mode;
      obs_q   <= target_band;
      feat[0] <= word_t'(WORD_W'(burst_avg) << FRAC_BITS);
      feat[1] <= word_t'(WORD_W'(io_wait) << FRAC_BITS);
      feat[2] <= word_t'(WORD_W'(age) << FRAC_BITS);
      feat[3] <= word_t'(WORD_W'(niceness) << FRAC_BITS);
    end
  end

  // band error scaled to a fixed-point word, wraps at 32 bits
  assign err = (WORD_W'(obs_q) - WORD_W'(pred_q)) << FRAC_BITS;

  // lane operand select per phase
  always_comb begin
    for (int i = 0; i < NUM_FEATURES; i++) begin
      lane_a[i] = weight[i];
      lane_b[i] = feat[i];
      if (state == S_UPD) begin
        lane_a[i] = lane_result[0];
      end
    end
    if (state == S_STEP) begin
      lane_a[0] = word_t'(WORD_W'(lrate));
      lane_b[0] = word_t'(err);
    end
  end

  for (genvar g = 0; g < NUM_FEATURES; g++) begin : g_lane
    lpp_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .load   (lane_load),
      .op_a   (lane_a[g]),
      .op_b   (lane_b[g]),
      .result (lane_result[g])
    );
  end

  lpp_merge #(
    .NUM_BANDS(NUM_BANDS),
    .FRAC_BITS(FRAC_BITS)
  ) u_merge (
    .clk         (clk),
    .load        (merge_load),
    .bias        (bias),
    .lane_result (lane_result),
    .pred        (pred)
  );

  // keep predicted band for the error, keep step for the bias
  always_ff @(posedge clk) begin
    if (state == S_BAND) begin
      pred_q <= pred;
    end
    if (state == S_UPD) begin
      step_q <= lane_result[0];
    end
  end

  // model state and learning rate
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FEATURES; i++) begin
        weight[i] <= W_RESET[i];
      end
      bias  <= BIAS_RESET;
      lrate <= LR_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lrate <= cfg_data;
      end
      if (state == S_APPLY) begin
        for (int i = 0; i < NUM_FEATURES; i++) begin
          weight[i] <= weight[i] + lane_result[i];
        end
        bias <= bias + step_q;
      end
    end
  end

  // output register
  assign pred_w = WORD_W'(pred);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      band <= pred_w[BAND_W-1:0];
    end
  end

  // a taken request always starts with the lane multiply
  a_take_to_mul: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == S_MUL)
    else $error("accepted request did not enter multiply phase");

  // clamp phase with a free output register produces a band word
  a_band_emitted: assert property (@(posedge clk) disable iff (rst)
    state == S_BAND && out_free |=> out_valid)
    else $error("band not presented after clamp phase");

  // model state only moves in the apply phase
  a_bias_hold: assert property (@(posedge clk) disable iff (rst)
    state != S_APPLY |=> $stable(bias) && $stable(weight[0]))
    else $error("model state changed outside apply phase");

  // a scoring request never enters the update phases
  a_score_only: assert property (@(posedge clk) disable iff (rst)
    state == S_BAND && out_free && !mode_q |=> state == S_IDLE)
    else $error("scoring request went on to update");

endmodule
